>>> design/rqpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqpr_pkg: shared types and constants for the ring queue with prefix reverse
// Operation and status codes and the fixed field widths of the item ports.
// ----------------------------------------------------------------------------
package rqpr_pkg;

    localparam int WORD_W = 32;
    localparam int K_W    = 11;
    localparam int OCC_W  = 11;

    localparam logic signed [WORD_W-1:0] EMPTY_FRONT = 32'shFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_REV  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BADK  = 2'd3
    } status_t;

endpackage

>>> design/rqpr_wrap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqpr_wrap: circular slot index unit
// Adds an offset to the head index and folds the sum back into the ring.
// ----------------------------------------------------------------------------
module rqpr_wrap #(
    parameter int DEPTH = 1024
) (
    input  logic [$clog2(DEPTH)-1:0] base,
    input  logic [$clog2(DEPTH)-1:0] offset,
    output logic [$clog2(DEPTH)-1:0] wrapped
);

    localparam int AW = $clog2(DEPTH);

    logic [AW:0] sum;

    // both operands stay below DEPTH, so one subtract folds the sum
    assign sum     = {1'b0, base} + {1'b0, offset};
    assign wrapped = (sum >= (AW+1)'(DEPTH)) ? AW'(sum - (AW+1)'(DEPTH)) : sum[AW-1:0];

endmodule

>>> design/rqpr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqpr_ram: single-port slot storage
// One access per cycle at a shared address; read data is registered.
// ----------------------------------------------------------------------------
module rqpr_ram #(
    parameter int DEPTH = 1024
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [$clog2(DEPTH)-1:0]    addr,
    input  logic [rqpr_pkg::WORD_W-1:0] wdata,
    output logic [rqpr_pkg::WORD_W-1:0] rdata
);

    import rqpr_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/ring_queue_with_prefix_reverse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_queue_with_prefix_reverse_core: circular queue with push, pop, reverse
// Queue of signed words held in a single-port RAM, run by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per transfer:
//   opcode, value (push only) and k_count (reverse only). Output channel
//   (out_valid/out_ready) returns exactly one result per operation: head entry
//   after the operation (-1 when empty), popped word, occupancy, empty flag
//   and status.
//   Path from input transfer to output valid: push, rejected operations and
//   the unused opcode pass through decode straight to the output register; a
//   pop that leaves entries behind adds a read of the new head from the RAM;
//   a reverse runs floor(k/2) swaps, each of four accesses of the single RAM
//   port (read a, read b, write a, write b). in_ready is low from the transfer
//   until the result moves into the output register and rises with
//   out_valid, so the next operation is not taken before then.
//   A result waits in the output register while the receiver stalls; the
//   next operation is taken meanwhile and its result holds until that
//   register empties.
//   Reset clears head, count and handshake state; the RAM is not cleared,
//   since only written entries are ever read.
// ----------------------------------------------------------------------------
module ring_queue_with_prefix_reverse_core #(
    parameter int DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         opcode,
    input  logic signed [rqpr_pkg::WORD_W-1:0] value,
    input  logic [rqpr_pkg::K_W-1:0]           k_count,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [rqpr_pkg::WORD_W-1:0] front_value,
    output logic signed [rqpr_pkg::WORD_W-1:0] removed_value,
    output logic [rqpr_pkg::OCC_W-1:0]         occupancy,
    output logic                               is_empty,
    output rqpr_pkg::status_t                  status
);

    import rqpr_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > K_W) ? CW : K_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POP_RD,
        S_RD_A,
        S_RD_B,
        S_WR_A,
        S_WR_B,
        S_DONE
    } state_t;

    state_t             state_reg,   state_next;
    op_t                op_reg,      op_next;
    logic [WORD_W-1:0]  value_reg,   value_next;
    logic [K_W-1:0]     k_reg,       k_next;
    logic [AW-1:0]      head_reg,    head_next;
    logic [CW-1:0]      count_reg,   count_next;
    logic [AW-1:0]      lo_reg,      lo_next;
    logic [AW-1:0]      hi_reg,      hi_next;
    logic [WORD_W-1:0]  front_reg,   front_next;
    logic [WORD_W-1:0]  tmp_reg,     tmp_next;
    logic [WORD_W-1:0]  removed_reg, removed_next;
    status_t            stat_reg,    stat_next;

    logic               ov_reg,      ov_next;
    logic [WORD_W-1:0]  fo_reg,      fo_next;
    logic [WORD_W-1:0]  ro_reg,      ro_next;
    logic [OCC_W-1:0]   occ_reg,     occ_next;
    logic               emp_reg,     emp_next;
    status_t            so_reg,      so_next;

    logic [AW-1:0]      offset;
    logic [AW-1:0]      slot_addr;
    logic               mem_we;
    logic [WORD_W-1:0]  mem_wdata;
    logic [WORD_W-1:0]  mem_rdata;
    logic [CMPW-1:0]    k_ext;
    logic [CMPW-1:0]    cnt_ext;
    logic [AW:0]        span;

    // shared index unit: every RAM access goes through head + offset
    rqpr_wrap #(
        .DEPTH (DEPTH)
    ) u_wrap (
        .base    (head_reg),
        .offset  (offset),
        .wrapped (slot_addr)
    );

    rqpr_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (slot_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign k_ext   = CMPW'(k_reg);
    assign cnt_ext = CMPW'(count_reg);
    assign span    = {1'b0, hi_reg} - {1'b0, lo_reg};

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        value_next   = value_reg;
        k_next       = k_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        front_next   = front_reg;
        tmp_next     = tmp_reg;
        removed_next = removed_reg;
        stat_next    = stat_reg;
        ov_next      = ov_reg;
        fo_next      = fo_reg;
        ro_next      = ro_reg;
        occ_next     = occ_reg;
        emp_next     = emp_reg;
        so_next      = so_reg;
        offset       = lo_reg;
        mem_we       = 1'b0;
        mem_wdata    = mem_rdata;

        // drop the held result once the receiver takes it
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = op_t'(opcode);
                    value_next   = value;
                    k_next       = k_count;
                    removed_next = '0;
                    stat_next    = ST_DONE;
                    state_next   = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_PUSH:
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            stat_next = ST_FULL;
                        end
                        else
                        begin
                            offset     = AW'(count_reg);
                            mem_we     = 1'b1;
                            mem_wdata  = value_reg;
                            count_next = count_reg + CW'(1);
                            if (count_reg == '0)
                            begin
                                front_next = value_reg;
                            end
                        end
                    end
                    OP_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            stat_next = ST_EMPTY;
                        end
                        else
                        begin
                            // advance head and read the new head in the same access
                            offset       = AW'(1);
                            removed_next = front_reg;
                            head_next    = (head_reg == AW'(DEPTH - 1)) ? '0
                                                                        : head_reg + AW'(1);
                            count_next   = count_reg - CW'(1);
                            if (count_reg > CW'(1))
                            begin
                                state_next = S_POP_RD;
                            end
                        end
                    end
                    OP_REV:
                    begin
                        if (k_ext <= CMPW'(1) || k_ext > cnt_ext)
                        begin
                            stat_next = ST_BADK;
                        end
                        else
                        begin
                            lo_next    = '0;
                            hi_next    = AW'(k_ext - CMPW'(1));
                            state_next = S_RD_A;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_POP_RD:
            begin
                front_next = mem_rdata;
                state_next = S_DONE;
            end

            S_RD_A:
            begin
                offset     = lo_reg;
                state_next = S_RD_B;
            end

            S_RD_B:
            begin
                offset     = hi_reg;
                tmp_next   = mem_rdata;
                state_next = S_WR_A;
            end

            S_WR_A:
            begin
                // entry b moves into slot a; on the first swap it is the new head
                offset    = lo_reg;
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                if (lo_reg == '0)
                begin
                    front_next = mem_rdata;
                end
                state_next = S_WR_B;
            end

            S_WR_B:
            begin
                offset    = hi_reg;
                mem_we    = 1'b1;
                mem_wdata = tmp_reg;
                if (span > (AW+1)'(2))
                begin
                    lo_next    = lo_reg + AW'(1);
                    hi_next    = hi_reg - AW'(1);
                    state_next = S_RD_A;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // hold here until the output register is free
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    fo_next    = (count_reg == '0) ? EMPTY_FRONT : front_reg;
                    ro_next    = removed_reg;
                    occ_next   = OCC_W'(count_reg);
                    emp_next   = (count_reg == '0);
                    so_next    = stat_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= OP_PUSH;
            value_reg   <= '0;
            k_reg       <= '0;
            head_reg    <= '0;
            count_reg   <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            front_reg   <= '0;
            tmp_reg     <= '0;
            removed_reg <= '0;
            stat_reg    <= ST_DONE;
            ov_reg      <= 1'b0;
            fo_reg      <= '0;
            ro_reg      <= '0;
            occ_reg     <= '0;
            emp_reg     <= 1'b0;
            so_reg      <= ST_DONE;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            value_reg   <= value_next;
            k_reg       <= k_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            front_reg   <= front_next;
            tmp_reg     <= tmp_next;
            removed_reg <= removed_next;
            stat_reg    <= stat_next;
            ov_reg      <= ov_next;
            fo_reg      <= fo_next;
            ro_reg      <= ro_next;
            occ_reg     <= occ_next;
            emp_reg     <= emp_next;
            so_reg      <= so_next;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = ov_reg;
    assign front_value   = fo_reg;
    assign removed_value = ro_reg;
    assign occupancy     = occ_reg;
    assign is_empty      = emp_reg;
    assign status        = so_reg;

    // occupancy never passes the ring size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above ring size");

    // an accepted operation closes the input in the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input reopened right after a transfer");

    // an empty queue reports the empty marker and no entries
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> front_value == EMPTY_FRONT && occupancy == '0)
        else $error("empty result with head value or entries");

    // a dropped push only happens with a full ring
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> occupancy == OCC_W'(DEPTH) && !is_empty)
        else $error("push dropped while ring not full");

endmodule

>>> verif/tb_ring_queue_with_prefix_reverse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ring_queue_with_prefix_reverse_core: self-checking bench for the queue
// Drives push, pop, prefix-reverse and the unused opcode through the valid/
// ready input channel and checks every result, field by field, against a
// behavioral queue kept in the bench. A short table of directed operations
// comes first, then randomized churn near empty, a fill to full with reverses
// mixed in, a stretch of work at the full boundary and more churn. Sender
// gaps and receiver stalls change every few dozen operations.
// ----------------------------------------------------------------------------
module tb_ring_queue_with_prefix_reverse_core;

    import rqpr_pkg::*;

    localparam int Q_DEPTH = 1024;

    // The package has no name for the spare opcode; the block treats it as a no-op.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_TARGET = 1450;
    localparam int MODE_SPAN     = 40;
    // Outlasts the longest reverse, of the whole queue; idle this long at the end.
    localparam int SETTLE_CYCLES = 2100;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] word;
        logic [10:0]        k;
    } op_item_t;

    typedef struct packed {
        logic signed [31:0] front;
        logic signed [31:0] removed;
        logic [10:0]        occ;
        logic               empty;
        status_t            stat;
    } result_t;

    typedef struct packed {
        op_item_t item;
        logic     pinned;
        result_t  want;
    } dir_row_t;

    typedef enum int {MIX_CHURN, MIX_FILL, MIX_FULL} mix_t;

    localparam result_t NO_WANT = '0;

    // Directed rows. Rows with pinned set carry a hand-written expectation
    // (empty queue, extreme words, rejections); the others use the predictor.
    localparam dir_row_t DIRECTED [25] = '{
        // pop and reverse on an empty queue, then the unused opcode
        '{'{OP_POP,    32'sh0000_0000, 11'd0},    1'b1,
          '{EMPTY_FRONT, 32'sd0, 11'd0, 1'b1, ST_EMPTY}},
        '{'{OP_REV,    32'sh0000_0000, 11'd2},    1'b1,
          '{EMPTY_FRONT, 32'sd0, 11'd0, 1'b1, ST_BADK}},
        '{'{OP_UNUSED, 32'sh1234_5678, 11'd5},    1'b1,
          '{EMPTY_FRONT, 32'sd0, 11'd0, 1'b1, ST_DONE}},
        // largest positive word, then reverses of zero and one entry
        '{'{OP_PUSH,   32'sh7FFF_FFFF, 11'd0},    1'b1,
          '{32'sh7FFF_FFFF, 32'sd0, 11'd1, 1'b0, ST_DONE}},
        '{'{OP_REV,    32'sh0000_0000, 11'd1},    1'b1,
          '{32'sh7FFF_FFFF, 32'sd0, 11'd1, 1'b0, ST_BADK}},
        '{'{OP_REV,    32'sh0000_0000, 11'd0},    1'b1,
          '{32'sh7FFF_FFFF, 32'sd0, 11'd1, 1'b0, ST_BADK}},
        // most negative word, all ones, zero
        '{'{OP_PUSH,   32'sh8000_0000, 11'd0},    1'b1,
          '{32'sh7FFF_FFFF, 32'sd0, 11'd2, 1'b0, ST_DONE}},
        '{'{OP_PUSH,   32'shFFFF_FFFF, 11'd0},    1'b1,
          '{32'sh7FFF_FFFF, 32'sd0, 11'd3, 1'b0, ST_DONE}},
        '{'{OP_PUSH,   32'sh0000_0000, 11'd0},    1'b1,
          '{32'sh7FFF_FFFF, 32'sd0, 11'd4, 1'b0, ST_DONE}},
        // k one above the count
        '{'{OP_REV,    32'sh0000_0000, 11'd5},    1'b1,
          '{32'sh7FFF_FFFF, 32'sd0, 11'd4, 1'b0, ST_BADK}},
        '{'{OP_REV,    32'sh0000_0000, 11'd4},    1'b0, NO_WANT},
        '{'{OP_REV,    32'sh0000_0000, 11'd2},    1'b0, NO_WANT},
        '{'{OP_REV,    32'shFFFF_FFFF, 11'd2047}, 1'b0, NO_WANT},
        '{'{OP_POP,    32'shFFFF_FFFF, 11'd2047}, 1'b0, NO_WANT},
        '{'{OP_UNUSED, 32'shFFFF_FFFF, 11'd2047}, 1'b0, NO_WANT},
        '{'{OP_PUSH,   32'sh5555_5555, 11'd0},    1'b0, NO_WANT},
        '{'{OP_PUSH,   32'shAAAA_AAAA, 11'd1365}, 1'b0, NO_WANT},
        // odd k, then the whole queue
        '{'{OP_REV,    32'sh0000_0000, 11'd3},    1'b0, NO_WANT},
        '{'{OP_REV,    32'sh0000_0000, 11'd5},    1'b0, NO_WANT},
        '{'{OP_POP,    32'sh0000_0000, 11'd0},    1'b0, NO_WANT},
        '{'{OP_POP,    32'sh0000_0000, 11'd0},    1'b0, NO_WANT},
        '{'{OP_POP,    32'sh0000_0000, 11'd0},    1'b0, NO_WANT},
        '{'{OP_POP,    32'sh0000_0000, 11'd0},    1'b0, NO_WANT},
        '{'{OP_POP,    32'sh0000_0000, 11'd0},    1'b0, NO_WANT},
        '{'{OP_POP,    32'sh0000_0000, 11'd0},    1'b1,
          '{EMPTY_FRONT, 32'sd0, 11'd0, 1'b1, ST_EMPTY}}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         opcode = 2'd0;
    logic signed [31:0] value = 32'sd0;
    logic [10:0]        k_count = 11'd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] front_value;
    logic signed [31:0] removed_value;
    logic [10:0]        occupancy;
    logic               is_empty;
    status_t            status;

    // Behavioral copy of the queue, advanced at each input transfer.
    logic signed [31:0] model_slots [Q_DEPTH];
    int                 model_head = 0;
    int                 model_count = 0;

    result_t            awaited_results [$];

    int feed_gap_pct    = 0;
    int drain_stall_pct = 0;
    int ops_sent        = 0;
    int results_checked = 0;
    int fail_count      = 0;
    int status_tally [4] = '{0, 0, 0, 0};
    int peak_occupancy  = 0;
    int longest_k       = 0;

    ring_queue_with_prefix_reverse_core #(
        .DEPTH(Q_DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .value        (value),
        .k_count      (k_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .front_value  (front_value),
        .removed_value(removed_value),
        .occupancy    (occupancy),
        .is_empty     (is_empty),
        .status       (status)
    );

    always #6 clk = ~clk;

    // Apply one operation to the bench queue and return what the block
    // should report afterwards.
    function automatic result_t apply_queue_op(logic [1:0] op, logic signed [31:0] word,
                                               logic [10:0] k);
        result_t            r;
        int                 lo;
        int                 hi;
        logic signed [31:0] held;
        r.removed = 32'sd0;
        r.stat    = ST_DONE;
        case (op)
            OP_PUSH:
            begin
                if (model_count >= Q_DEPTH)
                begin
                    r.stat = ST_FULL;
                end
                else
                begin
                    model_slots[(model_head + model_count) % Q_DEPTH] = word;
                    model_count++;
                end
            end
            OP_POP:
            begin
                if (model_count == 0)
                begin
                    r.stat = ST_EMPTY;
                end
                else
                begin
                    r.removed  = model_slots[model_head];
                    model_head = (model_head + 1) % Q_DEPTH;
                    model_count--;
                end
            end
            OP_REV:
            begin
                if (int'(k) <= 1 || int'(k) > model_count)
                begin
                    r.stat = ST_BADK;
                end
                else
                begin
                    // Swap from both ends of the prefix toward the middle.
                    lo = 0;
                    hi = int'(k) - 1;
                    while (lo < hi)
                    begin
                        held = model_slots[(model_head + lo) % Q_DEPTH];
                        model_slots[(model_head + lo) % Q_DEPTH] =
                            model_slots[(model_head + hi) % Q_DEPTH];
                        model_slots[(model_head + hi) % Q_DEPTH] = held;
                        lo++;
                        hi--;
                    end
                end
            end
            default: ;
        endcase
        r.front = (model_count == 0) ? EMPTY_FRONT : model_slots[model_head];
        r.occ   = model_count[10:0];
        r.empty = (model_count == 0);
        return r;
    endfunction

    // Choose a reverse length: mostly short prefixes, some up to the whole
    // queue, some rejected (too short, above the count, or with bit 10 set).
    function automatic logic [10:0] pick_k(int cnt);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return 11'($urandom_range(0, 1));
        else if (roll < 14)
            return 11'(cnt + 1 + int'($urandom_range(0, 3)));
        else if (roll < 20)
            return 11'($urandom_range(1025, 2047));
        else if (roll < 25)
            return 11'((cnt < 2) ? 2 : cnt);
        else if (roll < 40)
            return 11'($urandom_range(2, (cnt > 2) ? cnt : 2));
        else
            return 11'($urandom_range(2, 9));
    endfunction

    function automatic op_item_t make_item(mix_t mix);
        op_item_t it;
        int       roll;
        int       p_push;
        int       p_pop;
        int       p_rev;
        case (mix)
            MIX_FILL:
            begin
                p_push = 90;
                p_pop  = 2;
                p_rev  = 6;
            end
            MIX_FULL:
            begin
                p_push = 35;
                p_pop  = 25;
                p_rev  = 30;
            end
            default:
            begin
                p_push = 45;
                p_pop  = 40;
                p_rev  = 12;
            end
        endcase
        // Fill unused fields with noise too; the block must ignore them.
        it.word = $urandom;
        it.k    = 11'($urandom_range(0, 2047));
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       it.word = 32'sh8000_0000;
                1:       it.word = 32'sh7FFF_FFFF;
                2:       it.word = 32'shFFFF_FFFF;
                default: it.word = 32'sh0000_0000;
            endcase
        end
        roll = $urandom_range(0, 99);
        if (roll < p_push)
        begin
            it.op = OP_PUSH;
        end
        else if (roll < p_push + p_pop)
        begin
            it.op = OP_POP;
        end
        else if (roll < p_push + p_pop + p_rev)
        begin
            it.op = OP_REV;
            it.k  = pick_k(model_count);
        end
        else
        begin
            it.op = OP_UNUSED;
        end
        return it;
    endfunction

    // Present one operation and hold it until the transfer; then advance the
    // bench queue and queue up the expected result.
    task automatic send_item(input op_item_t it);
        result_t outcome;
        // Rotate the idling pattern: none, sender gaps, receiver stalls, both.
        case ((ops_sent / MODE_SPAN) % 4)
            0:
            begin
                feed_gap_pct    = 0;
                drain_stall_pct = 0;
            end
            1:
            begin
                feed_gap_pct    = 61;
                drain_stall_pct = 0;
            end
            2:
            begin
                feed_gap_pct    = 0;
                drain_stall_pct = 61;
            end
            default:
            begin
                feed_gap_pct    = 33;
                drain_stall_pct = 33;
            end
        endcase
        while ($urandom_range(0, 99) < feed_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= it.op;
        value    <= it.word;
        k_count  <= it.k;
        do @(posedge clk); while (!in_ready);
        outcome = apply_queue_op(it.op, it.word, it.k);
        awaited_results.push_back(outcome);
        ops_sent++;
        status_tally[outcome.stat]++;
        if (model_count > peak_occupancy)
            peak_occupancy = model_count;
        if (it.op == OP_REV && outcome.stat == ST_DONE && int'(it.k) > longest_k)
            longest_k = int'(it.k);
    endtask

    // Drop valid and hold off until every outstanding result has come back.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (awaited_results.size() != 0);
    endtask

    // Result side: check each transfer against the oldest expectation and
    // pick a fresh random ready for the next cycle.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (awaited_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("[%0t] result with nothing outstanding: front=%0d occ=%0d",
                             $realtime, front_value, occupancy);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (front_value !== want.front || removed_value !== want.removed ||
                    occupancy !== want.occ || is_empty !== want.empty ||
                    status !== want.stat)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("[%0t] mismatch on result %0d", $realtime, results_checked);
                        $display("  expected front=%0d removed=%0d occ=%0d empty=%0b st=%0d",
                                 want.front, want.removed, want.occ, want.empty, want.stat);
                        $display("  actual   front=%0d removed=%0d occ=%0d empty=%0b st=%0d",
                                 front_value, removed_value, occupancy, is_empty, status);
                    end
                end
            end
        end
        out_ready <= ($urandom_range(0, 99) >= drain_stall_pct);
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; pin the hand-written expectation where there is one.
        foreach (DIRECTED[i])
        begin
            send_item(DIRECTED[i].item);
            if (DIRECTED[i].pinned)
                awaited_results[awaited_results.size() - 1] = DIRECTED[i].want;
        end

        // Churn near empty: plenty of pops on an empty queue and short reverses.
        repeat (230) send_item(make_item(MIX_CHURN));
        hold_until_drained();

        // Fill to the brim with reverses of growing prefixes mixed in.
        while (model_count < Q_DEPTH)
            send_item(make_item(MIX_FILL));
        hold_until_drained();

        // At full: dropped push, whole-queue reverse, one short of it, one over.
        send_item('{OP_PUSH, 32'sh0BAD_F00D, 11'd0});
        send_item('{OP_REV, 32'sh0000_0000, 11'(Q_DEPTH)});
        send_item('{OP_REV, 32'sh0000_0000, 11'(Q_DEPTH - 1)});
        send_item('{OP_REV, 32'sh0000_0000, 11'(Q_DEPTH + 1)});
        repeat (60) send_item(make_item(MIX_FULL));

        while (ops_sent < RANDOM_TARGET)
            send_item(make_item(MIX_CHURN));

        in_valid <= 1'b0;
        drain_stall_pct = 0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        // Stay around long enough to catch any result the block makes up.
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d operations, %0d results checked; peak occupancy %0d,",
                 ops_sent, results_checked, peak_occupancy);
        $display("longest reverse %0d; rejections: %0d pushes on full, %0d pops on empty, %0d bad k",
                 longest_k, status_tally[ST_FULL], status_tally[ST_EMPTY],
                 status_tally[ST_BADK]);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Guard against a hung handshake; far beyond the slowest legal run.
    initial
    begin
        #200_000_000;
        $display("timeout: %0d results still outstanding", awaited_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
